@@ design/tape_machine_op_executor_core_assert.svh @@
// Assertion helpers shared by the RTL.
`ifndef TAPE_MACHINE_OP_EXECUTOR_CORE_ASSERT_SVH
`define TAPE_MACHINE_OP_EXECUTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define TMOE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmoe assertion failed");

// Next-cycle implication.
`define TMOE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmoe assertion failed");

`endif

@@ design/tmoe_pkg.sv @@
package tmoe_pkg;

  localparam int PTR_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 3;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_ADD_CONST = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_CONST = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_CELL  = 3'd2;
  localparam logic [OP_W-1:0] OP_MOVE      = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL_ADD   = 3'd4;
  localparam logic [OP_W-1:0] OP_PRINT     = 3'd5;
  localparam logic [OP_W-1:0] OP_READ      = 3'd6;
  localparam logic [OP_W-1:0] OP_TEST      = 3'd7;

  localparam logic RESULT_CHAR = 1'b0;
  localparam logic RESULT_TEST = 1'b1;

endpackage

@@ design/tmoe_ram.sv @@
module tmoe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ design/tmoe_addr_wrap.sv @@
// (base + offset) mod 2^16, then mod TAPE_CELLS. Free-running, three register
// stages (sum, product, remainder) and a combinational final correction.
module tmoe_addr_wrap #(
  parameter int TAPE_CELLS = 65536
) (
  input  logic                          clk,
  input  logic [tmoe_pkg::PTR_W-1:0]    base,
  input  logic [tmoe_pkg::PTR_W-1:0]    offset,
  output logic [$clog2(TAPE_CELLS)-1:0] addr
);

  localparam int AW = $clog2(TAPE_CELLS);
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(TAPE_CELLS);
  localparam int RECIP_W = $clog2(RECIP64 + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);
  localparam int PW = tmoe_pkg::PTR_W + RECIP_W;
  localparam int QW = PW - 32;
  localparam logic [tmoe_pkg::PTR_W:0] T_EXT = (tmoe_pkg::PTR_W + 1)'(TAPE_CELLS);

  logic [tmoe_pkg::PTR_W-1:0] sum_q;
  logic [tmoe_pkg::PTR_W-1:0] sum_d;
  logic [PW-1:0]              prod_q;
  logic [tmoe_pkg::PTR_W-1:0] rem_q;
  logic [QW-1:0]              quot;
  logic [tmoe_pkg::PTR_W:0]   rem_ext;

  // quotient estimate is exact or one low, so one correction step suffices
  assign quot = prod_q[PW-1:32];

  always_ff @(posedge clk) begin
    sum_q  <= base + offset;
    prod_q <= PW'(sum_q) * PW'(RECIP);
    sum_d  <= sum_q;
    rem_q  <= sum_d - tmoe_pkg::PTR_W'(32'(quot) * 32'(T_EXT));
  end

  always_comb begin
    rem_ext = {1'b0, rem_q};
    if (rem_ext >= T_EXT) begin
      rem_ext = rem_ext - T_EXT;
    end
    addr = rem_ext[AW-1:0];
  end

endmodule

@@ design/tape_machine_op_executor_core.sv @@
// Byte-tape operation executor. One operation per request on the slave stream;
// print and test answers leave on the master stream, repeat_count copies of the
// cell byte for a print, one byte for a test, tlast on the final byte. After reset
// the tape is cleared one cell per cycle, so no request is taken until every cell
// is cleared. A pointer move is done at acceptance. Every other operation goes
// through accept, three stages of address reduction modulo TAPE_CELLS, one tape
// read and one write-back, all through a single tape memory. Results drain at one
// per cycle while m_tready is high from an output register as the next operations
// run; a print or test waits in write-back until the previous run has drained.
`include "tape_machine_op_executor_core_assert.svh"

module tape_machine_op_executor_core #(
  parameter int TAPE_CELLS = 65536,
  parameter int MAX_REPEAT = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // target_offset[15:0], source_offset[31:16], amount[47:32], multiplier[55:48],
  // repeat_count[62:56], input_byte[70:63], zero[71]
  input  logic [tmoe_pkg::S_DATA_W-1:0]   s_tdata,
  // opcode[2:0]
  input  logic [tmoe_pkg::OP_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_byte[7:0], cell_nonzero[8], zero[15:9]
  output logic [tmoe_pkg::M_DATA_W-1:0]   m_tdata,
  // result_kind[0]
  output logic                            m_tuser,
  output logic                            m_tlast
);

  localparam int AW    = $clog2(TAPE_CELLS);
  localparam int CNT_W = $clog2(MAX_REPEAT + 1);
  localparam int PW    = tmoe_pkg::PTR_W;
  localparam int BW    = tmoe_pkg::BYTE_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0]                 state;
  logic [1:0]                 wait_cnt;
  logic [AW-1:0]              clear_addr;
  logic [PW-1:0]              ptr;

  logic [tmoe_pkg::OP_W-1:0]  op;
  logic [PW-1:0]              tgt_off;
  logic [PW-1:0]              src_off;
  logic [BW-1:0]              amount_lo;
  logic [BW-1:0]              mult;
  logic [CNT_W-1:0]           reps;
  logic [BW-1:0]              in_byte;

  logic                       out_valid;
  logic [BW-1:0]              out_byte;
  logic                       out_kind;
  logic                       out_nz;
  logic [CNT_W-1:0]           out_cnt;

  logic [AW-1:0]              dst_addr;
  logic [AW-1:0]              src_addr;
  logic [BW-1:0]              dst_byte;
  logic [BW-1:0]              src_byte;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [BW-1:0]              ram_wdata;
  logic [BW-1:0]              new_byte;
  logic                       op_writes;
  logic                       op_emits;
  logic                       exec_stall;
  logic                       accept;
  logic [CNT_W-1:0]           reps_sat;
  logic [6:0]                 rc_field;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign rc_field = s_tdata[62:56];
  assign reps_sat = (32'(rc_field) > MAX_REPEAT) ? CNT_W'(MAX_REPEAT) : CNT_W'(rc_field);

  tmoe_addr_wrap #(.TAPE_CELLS(TAPE_CELLS)) u_dst_wrap (
    .clk    (clk),
    .base   (ptr),
    .offset (tgt_off),
    .addr   (dst_addr)
  );

  tmoe_addr_wrap #(.TAPE_CELLS(TAPE_CELLS)) u_src_wrap (
    .clk    (clk),
    .base   (ptr),
    .offset (src_off),
    .addr   (src_addr)
  );

  tmoe_ram #(.WIDTH(BW), .DEPTH(TAPE_CELLS)) u_tape (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (dst_addr),
    .rdata_a (dst_byte),
    .raddr_b (src_addr),
    .rdata_b (src_byte)
  );

  always_comb begin
    op_writes = (op == tmoe_pkg::OP_ADD_CONST) || (op == tmoe_pkg::OP_SET_CONST) ||
                (op == tmoe_pkg::OP_ADD_CELL)  || (op == tmoe_pkg::OP_MUL_ADD)   ||
                (op == tmoe_pkg::OP_READ);
    op_emits  = (op == tmoe_pkg::OP_PRINT && reps != '0) || (op == tmoe_pkg::OP_TEST);
    exec_stall = op_emits && out_valid;
    case (op)
      tmoe_pkg::OP_ADD_CONST: new_byte = dst_byte + amount_lo;
      tmoe_pkg::OP_SET_CONST: new_byte = amount_lo;
      tmoe_pkg::OP_ADD_CELL:  new_byte = dst_byte + src_byte;
      tmoe_pkg::OP_MUL_ADD:   new_byte = dst_byte + BW'(mult * src_byte);
      tmoe_pkg::OP_READ:      new_byte = in_byte;
      default:                new_byte = dst_byte;
    endcase
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_EXEC) && op_writes;
      ram_waddr = dst_addr;
      ram_wdata = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      wait_cnt   <= '0;
      clear_addr <= '0;
      ptr        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == AW'(TAPE_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == tmoe_pkg::OP_MOVE) begin
              ptr <= ptr + s_tdata[47:32];
            end else begin
              state    <= S_ADDR;
              wait_cnt <= '0;
            end
          end
        end
        S_ADDR: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == 2'd2) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (!exec_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture; test reads the cell under the pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= s_tuser;
      tgt_off   <= (s_tuser == tmoe_pkg::OP_TEST) ? '0 : s_tdata[15:0];
      src_off   <= s_tdata[31:16];
      amount_lo <= s_tdata[39:32];
      mult      <= s_tdata[55:48];
      reps      <= reps_sat;
      in_byte   <= s_tdata[70:63];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_cnt   <= '0;
    end else if (state == S_EXEC && op_emits && !out_valid) begin
      out_valid <= 1'b1;
      out_cnt   <= (op == tmoe_pkg::OP_TEST) ? CNT_W'(1) : reps;
    end else if (out_valid && m_tready) begin
      out_cnt <= out_cnt - 1'b1;
      if (out_cnt == CNT_W'(1)) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && op_emits && !out_valid) begin
      out_byte <= dst_byte;
      if (op == tmoe_pkg::OP_TEST) begin
        out_kind <= tmoe_pkg::RESULT_TEST;
        out_nz   <= (dst_byte != '0);
      end else begin
        out_kind <= tmoe_pkg::RESULT_CHAR;
        out_nz   <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_nz, out_byte};
  assign m_tuser  = out_kind;
  assign m_tlast  = (out_cnt == CNT_W'(1));

  `TMOE_ASSERT_IMP(a_cnt_live, clk, rst, out_valid, (out_cnt != '0) && (32'(out_cnt) <= MAX_REPEAT))
  `TMOE_ASSERT_NXT(a_drain_done, clk, rst, out_valid && m_tready && m_tlast, !out_valid)
  `TMOE_ASSERT_IMP(a_write_ops, clk, rst, ram_we && state != S_CLEAR, op_writes && !op_emits)
  `TMOE_ASSERT_NXT(a_ptr_hold, clk, rst, !(accept && s_tuser == tmoe_pkg::OP_MOVE), $stable(ptr))

endmodule
